FILE: hdl/bump_allocator_with_slot_ledger_unit_macros.svh
// Assertion macros used by the checker of the allocator.
`ifndef BUMP_ALLOCATOR_WITH_SLOT_LEDGER_UNIT_MACROS_SVH
`define BUMP_ALLOCATOR_WITH_SLOT_LEDGER_UNIT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is high.
`define BALS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Assert that a condition holds on every clock edge outside reset.
`define BALS_ASSERT_ALWAYS(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

`endif

FILE: hdl/bals_pkg.sv
// Types, codes and default sizes shared by the allocator modules.
package bals_pkg;

  localparam int DEF_ARENA_BYTES  = 65536;
  localparam int DEF_LEDGER_SLOTS = 16;
  localparam int DEF_ALIGN_LIMIT  = 4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOMEM   = 2'd3
  } status_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] align;
    logic [23:0] size;
    logic [15:0] ptr_offset;
    logic        ptr_null;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] offset;
    logic [16:0] watermark;
    logic [4:0]  live_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

FILE: hdl/bals_ctrl.sv
// Request sequencer: captures a request, then runs it once the result register is free.
module bals_ctrl import bals_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  output ctl_t ctl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);
  assign ctl.load  = req_valid && (state == S_IDLE);
  assign ctl.exec  = (state == S_EXEC) && rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ctl.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/bals_dp.sv
// Datapath: bump pointer, slot ledger, request and result registers.
module bals_dp import bals_pkg::*; #(
  parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
  parameter int LEDGER_SLOTS = DEF_LEDGER_SLOTS,
  parameter int ALIGN_LIMIT  = DEF_ALIGN_LIMIT
) (
  input  logic clk,
  input  logic rst,
  input  ctl_t ctl,
  input  req_t req_in,
  output rsp_t rsp
);

  localparam int BP_W  = $clog2(ARENA_BYTES + 1);
  localparam int SUM_W = ((BP_W > 24) ? BP_W : 24) + 2;
  localparam int IDX_W = (LEDGER_SLOTS > 1) ? $clog2(LEDGER_SLOTS) : 1;
  localparam int CNT_W = $clog2(LEDGER_SLOTS + 1);
  localparam int LC_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [SUM_W-1:0] ARENA_TOP = SUM_W'(ARENA_BYTES);
  localparam logic [16:0]      ALIGN_MAX = 17'(ALIGN_LIMIT);

  req_t                    req_q;
  logic [BP_W-1:0]         bump;
  logic [BP_W-1:0]         bump_next;
  logic [LEDGER_SLOTS-1:0] live;
  logic [LEDGER_SLOTS-1:0] live_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [15:0]             slot_off [LEDGER_SLOTS];

  logic [SUM_W-1:0] a_mask;
  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] top_addr;
  logic [SUM_W-1:0] sz_ext;
  logic [SUM_W-1:0] wm_ext;
  logic [LC_W-1:0]  cnt_ext;
  logic             align_ok;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             ok_alloc;
  logic             ok_free;
  status_t          st;
  rsp_t             rsp_next;

  assign a_mask   = SUM_W'(req_q.align) - SUM_W'(1);
  assign sz_ext   = SUM_W'(req_q.size);
  assign base     = (SUM_W'(bump) + a_mask) & ~a_mask;
  assign top_addr = base + sz_ext;
  assign align_ok = (req_q.align != '0) && ({1'b0, req_q.align} <= ALIGN_MAX) &&
                    ((req_q.align & (req_q.align - 16'd1)) == '0);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit_found  = 1'b0;
    hit_idx    = '0;
    for (int i = LEDGER_SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
      if (live[i] && (slot_off[i] == req_q.ptr_offset)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    st = ST_OK;
    if (req_q.cmd == CMD_ALLOC) begin
      priority if (!align_ok || (req_q.size == '0)) begin
        st = ST_INVALID;
      end else if (sz_ext > ARENA_TOP) begin
        st = ST_RANGE;
      end else if (top_addr > ARENA_TOP) begin
        st = ST_NOMEM;
      end else if (!free_found) begin
        st = ST_NOMEM;
      end else begin
        st = ST_OK;
      end
    end else begin
      priority if (req_q.ptr_null || !hit_found) begin
        st = ST_INVALID;
      end else begin
        st = ST_OK;
      end
    end
  end

  assign ok_alloc = (req_q.cmd == CMD_ALLOC) && (st == ST_OK);
  assign ok_free  = (req_q.cmd == CMD_FREE) && (st == ST_OK);

  always_comb begin
    live_next  = live;
    bump_next  = bump;
    count_next = count;
    if (ok_alloc) begin
      live_next[free_idx] = 1'b1;
      bump_next           = top_addr[BP_W-1:0];
      count_next          = count + CNT_W'(1);
    end else if (ok_free) begin
      live_next[hit_idx] = 1'b0;
      count_next         = count - CNT_W'(1);
    end
  end

  assign wm_ext  = SUM_W'(bump_next);
  assign cnt_ext = LC_W'(count_next);

  always_comb begin
    rsp_next.status     = st;
    rsp_next.offset     = ok_alloc ? base[15:0] : 16'd0;
    rsp_next.watermark  = wm_ext[16:0];
    rsp_next.live_count = cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump  <= '0;
      live  <= '0;
      count <= '0;
    end else if (ctl.exec) begin
      bump  <= bump_next;
      live  <= live_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= req_in;
    end
    if (ctl.exec) begin
      rsp <= rsp_next;
      if (ok_alloc) begin
        slot_off[free_idx] <= base[15:0];
      end
    end
  end

endmodule

FILE: hdl/bump_allocator_with_slot_ledger_unit.sv
// Top level of the bump-pointer arena allocator with a live-slot ledger.
// Each request is first captured in the request register and then evaluated: the
// watermark is rounded to the alignment, the arena bound checked, the ledger searched
// (all slots compared in parallel) and state and the result register updated. A new
// request is taken only on the cycle after the last evaluation; a result waiting in
// the result register holds up only the evaluation of the next request. Ledger
// offsets need no clearing after reset: only live slots are compared.
module bump_allocator_with_slot_ledger_unit import bals_pkg::*; #(
  parameter int ARENA_BYTES  = DEF_ARENA_BYTES,
  parameter int LEDGER_SLOTS = DEF_LEDGER_SLOTS,
  parameter int ALIGN_LIMIT  = DEF_ALIGN_LIMIT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctl_t ctl;

  bals_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .ctl       (ctl)
  );

  bals_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .LEDGER_SLOTS (LEDGER_SLOTS),
    .ALIGN_LIMIT  (ALIGN_LIMIT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .req_in (req),
    .rsp    (rsp)
  );

endmodule

FILE: hdl/bals_checker.sv
// Port-level checks on the allocator, bound to the top level.
`include "bump_allocator_with_slot_ledger_unit_macros.svh"

module bals_checker import bals_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  `BALS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")
  `BALS_ASSERT_ALWAYS(a_fail_no_offset, clk, rst, !rsp_valid || rsp.status == ST_OK || rsp.offset == 16'd0, "failed request reports an offset")
  `BALS_ASSERT(a_rsp_after_busy, clk, rst, !rsp_valid ##1 rsp_valid |-> $past(req_stall), "result without a pending request")
  `BALS_ASSERT(a_one_at_a_time, clk, rst, req_valid && !req_stall |=> req_stall, "second request taken while one is pending")

endmodule

bind bump_allocator_with_slot_ledger_unit bals_checker u_bals_checker (.*);
